// File: rtl/tvi_pkg.sv
// ----------------------------------------------------------------------------
// tvi_pkg
// Shared constants, codes and types of the voxel integration pipeline.
// ----------------------------------------------------------------------------
package tvi_pkg;

  localparam int DEPTH_WORDS = 1048576;
  localparam int GRID_SIDE   = 1024;
  localparam int ADDR_W      = (DEPTH_WORDS > 1) ? $clog2(DEPTH_WORDS) : 1;
  localparam int FRAME_WORDS = 15;

  localparam logic [1:0] ACT_DEPTH = 2'd0;
  localparam logic [1:0] ACT_FRAME = 2'd1;
  localparam logic [1:0] ACT_VOXEL = 2'd2;

  localparam logic [3:0] REG_FOCAL_X      = 4'd0;
  localparam logic [3:0] REG_FOCAL_Y      = 4'd1;
  localparam logic [3:0] REG_CENTRE_X     = 4'd2;
  localparam logic [3:0] REG_CENTRE_Y     = 4'd3;
  localparam logic [3:0] REG_VOXEL_SIZE   = 4'd4;
  localparam logic [3:0] REG_TRUNC_MARGIN = 4'd5;
  localparam logic [3:0] REG_IMAGE_WIDTH  = 4'd6;
  localparam logic [3:0] REG_IMAGE_HEIGHT = 4'd7;

  localparam logic [30:0] VOXEL_SIZE_RST   = 31'd2621;
  localparam logic [30:0] TRUNC_MARGIN_RST = 31'd10486;
  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd480;
  localparam logic [10:0] IMAGE_HEIGHT_RST = 11'd640;

  // control and payload that travels with every pipeline slot
  typedef struct packed {
    logic                valid;
    logic                live;
    logic                wr;
    logic [ADDR_W-1:0]   waddr;
    logic [15:0]         wdata;
    logic signed [15:0]  od;
    logic [15:0]         ow;
    logic signed [31:0]  z;
  } slot_t;

endpackage

// File: rtl/tvi_if.sv
// ----------------------------------------------------------------------------
// tvi_if
// Valid/ready channels of the voxel integration block: items, results, config.
// ----------------------------------------------------------------------------
interface tvi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [19:0]        load_index;
  logic [15:0]        depth_mm;
  logic signed [31:0] frame_word;
  logic [9:0]         grid_x;
  logic [9:0]         grid_y;
  logic [9:0]         grid_z;
  logic signed [15:0] old_distance;
  logic [15:0]        old_weight;

  modport source (output valid, action, load_index, depth_mm, frame_word, grid_x, grid_y,
                  grid_z, old_distance, old_weight, input ready);
  modport sink (input valid, action, load_index, depth_mm, frame_word, grid_x, grid_y,
                grid_z, old_distance, old_weight, output ready);
endinterface

interface tvi_out_if;
  logic               valid;
  logic               ready;
  logic               updated;
  logic signed [15:0] new_distance;
  logic [15:0]        new_weight;

  modport source (output valid, updated, new_distance, new_weight, input ready);
  modport sink (input valid, updated, new_distance, new_weight, output ready);
endinterface

interface tvi_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  addr;
  logic [31:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// File: rtl/tvi_ram.sv
// ----------------------------------------------------------------------------
// tvi_ram
// Generic single-port RAM with registered read and clock enable.
// ----------------------------------------------------------------------------
module tvi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/tsdf_voxel_integrate_core.sv
// ----------------------------------------------------------------------------
// tsdf_voxel_integrate_core
// Truncated signed distance fusion of one depth frame, one voxel per cycle.
// ----------------------------------------------------------------------------
// items: depth pixel loads, frame word loads (rotation, translation, origin)
// and voxels. every item gives exactly one transaction on results, in order;
// loads answer all zero, a voxel answers its fused or unchanged distance and
// weight. cfg writes the eight camera/grid registers; the user must write
// them only while idle, the block does not enforce it. throughput: one item
// per cycle while results is not stalled; the pipeline holds 57 items plus
// the output register. each divide (pixel column and row, truncated distance,
// weighted average) is a restoring divider with one quotient bit per stage,
// which sets the depth. the depth store is one single-port RAM; a load writes
// it at the same stage where voxels read it, so ordering is kept.
// reset clears the configuration to defaults and empties the pipeline; the
// depth and frame stores are not cleared and must be loaded before use.
// when results is stalled the whole pipeline holds and items.ready drops.
// ----------------------------------------------------------------------------
module tsdf_voxel_integrate_core
  import tvi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tvi_in_if.sink    items,
  tvi_out_if.source results,
  tvi_cfg_if.sink   cfg
);

  localparam int NST    = 57;
  localparam int S_DIVX = 6;
  localparam int NDIVX  = 11;
  localparam int S_DIVT = 22;
  localparam int NDIVT  = 15;
  localparam int S_DIVA = 39;
  localparam int NDIVA  = 17;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return $signed(v[31:0]);
  endfunction

  // configuration
  logic [30:0]        focal_x, focal_y, voxel_size, trunc_margin;
  logic signed [31:0] centre_x, centre_y;
  logic [10:0]        image_width, image_height;
  logic [40:0]        lim;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= '0;
      focal_y      <= '0;
      centre_x     <= '0;
      centre_y     <= '0;
      voxel_size   <= VOXEL_SIZE_RST;
      trunc_margin <= TRUNC_MARGIN_RST;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_FOCAL_X:      focal_x      <= cfg.data[30:0];
        REG_FOCAL_Y:      focal_y      <= cfg.data[30:0];
        REG_CENTRE_X:     centre_x     <= $signed(cfg.data);
        REG_CENTRE_Y:     centre_y     <= $signed(cfg.data);
        REG_VOXEL_SIZE:   voxel_size   <= cfg.data[30:0];
        REG_TRUNC_MARGIN: trunc_margin <= cfg.data[30:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data[10:0];
        default: ;
      endcase
    end
  end

  // truncation limit in units of 1/(1000*65536) metre
  always_ff @(posedge clk) begin
    lim <= 41'(trunc_margin) * 41'd1000;
  end

  // pipeline control
  logic  adv;
  slot_t slot [NST];
  slot_t slot0;

  assign adv         = !results.valid || results.ready;
  assign items.ready = adv;

  // frame store
  logic signed [31:0] frame [FRAME_WORDS];

  always_ff @(posedge clk) begin
    if (items.valid && adv && items.action == ACT_FRAME &&
        items.load_index < 20'(FRAME_WORDS)) begin
      frame[items.load_index[3:0]] <= items.frame_word;
    end
  end

  logic is_vox, grid_ok;
  logic [9:0] gin [3];

  assign gin[0] = items.grid_x;
  assign gin[1] = items.grid_y;
  assign gin[2] = items.grid_z;

  always_comb begin
    is_vox  = items.action == ACT_VOXEL;
    grid_ok = (32'(items.grid_x) < 32'(GRID_SIDE)) && (32'(items.grid_y) < 32'(GRID_SIDE)) &&
              (32'(items.grid_z) < 32'(GRID_SIDE));
    slot0.valid = items.valid;
    slot0.live  = is_vox && grid_ok;
    slot0.wr    = (items.action == ACT_DEPTH) &&
                  (32'(items.load_index) < 32'(DEPTH_WORDS));
    slot0.waddr = ADDR_W'(items.load_index);
    slot0.wdata = items.depth_mm;
    slot0.od    = is_vox ? items.old_distance : 16'sd0;
    slot0.ow    = is_vox ? items.old_weight : 16'd0;
    slot0.z     = '0;
  end

  // stage combinational results that also update the slot
  logic signed [63:0] cam_sum [3];
  logic signed [31:0] cam_nx [3];
  logic               pix_ok;
  logic signed [43:0] neg_lim, pos_lim;

  // pixel check and depth address
  logic [10:0]        px, py;
  logic [21:0]        pix_addr, pix_addr_nx;
  logic               addr_ok;

  // divider chains
  logic [47:0]        remx [NDIVX+1], remy [NDIVX+1];
  logic [NDIVX-1:0]   qx [NDIVX+1], qy [NDIVX+1];
  logic               ovfx [NDIVX+1], ovfy [NDIVX+1], negx [NDIVX+1], negy [NDIVX+1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cam_sum[j] = (m2[j*3] >>> 16) + (m2[j*3+1] >>> 16) + (m2[j*3+2] >>> 16);
      cam_nx[j]  = sat32(cam_sum[j]);
    end
    pix_ok = !ovfx[NDIVX] && (qx[NDIVX] < image_width) && !(negx[NDIVX] && qx[NDIVX] != '0) &&
             !ovfy[NDIVX] && (qy[NDIVX] < image_height) && !(negy[NDIVX] && qy[NDIVX] != '0);
    pos_lim = $signed({3'b000, lim});
    neg_lim = -pos_lim;
    pix_addr_nx = 22'(py) * 22'(image_width) + 22'(px);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) begin
        slot[i].valid <= 1'b0;
      end
    end else if (adv) begin
      slot[0] <= slot0;
      for (int i = 1; i < NST; i++) begin
        slot[i] <= slot[i-1];
      end
      slot[3].z    <= cam_nx[2];
      slot[4].live <= slot[3].live && (slot[3].z > 32'sd0);
      slot[18].live <= slot[17].live && pix_ok;
      slot[22].live <= slot[21].live && (dnum > neg_lim);
    end
  end

  // stage 0: grid products and origin minus camera position
  logic [40:0]        gp [3];
  logic signed [32:0] ot [3];
  logic signed [31:0] r0 [9], r1 [9];
  logic signed [31:0] d1 [3];
  logic signed [63:0] m2 [9];
  logic signed [31:0] cam3 [2];
  logic signed [63:0] fxa, cxz, fyb, cyz;
  logic [47:0]        nx5, ny5;
  logic               negx5, negy5;
  logic signed [63:0] sx, sy;
  logic [63:0]        magx, magy, sumx, sumy;

  always_comb begin
    sx   = fxa + cxz;
    sy   = fyb + cyz;
    magx = sx[63] ? 64'(-sx) : 64'(sx);
    magy = sy[63] ? 64'(-sy) : 64'(sy);
    sumx = magx + {17'b0, slot[4].z, 15'b0};
    sumy = magy + {17'b0, slot[4].z, 15'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        gp[k] <= 41'(gin[k]) * 41'(voxel_size);
        ot[k] <= 33'(frame[12+k]) - 33'(frame[9+k]);
        d1[k] <= sat32(64'(ot[k]) + $signed({23'b0, gp[k]}));
      end
      for (int i = 0; i < 9; i++) begin
        r0[i] <= frame[i];
        r1[i] <= r0[i];
      end
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          m2[j*3+k] <= 64'(r1[k*3+j]) * 64'(d1[k]);
        end
      end
      cam3[0] <= cam_nx[0];
      cam3[1] <= cam_nx[1];
      // projection numerators
      fxa <= 64'($signed({1'b0, focal_x})) * 64'(cam3[0]);
      cxz <= 64'(centre_x) * 64'(slot[3].z);
      fyb <= 64'($signed({1'b0, focal_y})) * 64'(cam3[1]);
      cyz <= 64'(centre_y) * 64'(slot[3].z);
      // rounding half away from zero, then drop the 2^16 of the divisor
      negx5 <= sx[63];
      negy5 <= sy[63];
      nx5   <= sumx[63:16];
      ny5   <= sumy[63:16];
      // divider entry
      remx[0] <= nx5;
      remy[0] <= ny5;
      qx[0]   <= '0;
      qy[0]   <= '0;
      negx[0] <= negx5;
      negy[0] <= negy5;
      ovfx[0] <= nx5 >= {5'b0, slot[5].z, 11'b0};
      ovfy[0] <= ny5 >= {5'b0, slot[5].z, 11'b0};
    end
  end

  // pixel column and row dividers, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NDIVX; k++) begin
        if (remx[k] >= ({16'b0, slot[S_DIVX+k].z} << (NDIVX-1-k))) begin
          remx[k+1] <= remx[k] - ({16'b0, slot[S_DIVX+k].z} << (NDIVX-1-k));
          qx[k+1]   <= {qx[k][NDIVX-2:0], 1'b1};
        end else begin
          remx[k+1] <= remx[k];
          qx[k+1]   <= {qx[k][NDIVX-2:0], 1'b0};
        end
        if (remy[k] >= ({16'b0, slot[S_DIVX+k].z} << (NDIVX-1-k))) begin
          remy[k+1] <= remy[k] - ({16'b0, slot[S_DIVX+k].z} << (NDIVX-1-k));
          qy[k+1]   <= {qy[k][NDIVX-2:0], 1'b1};
        end else begin
          remy[k+1] <= remy[k];
          qy[k+1]   <= {qy[k][NDIVX-2:0], 1'b0};
        end
        ovfx[k+1] <= ovfx[k];
        ovfy[k+1] <= ovfy[k];
        negx[k+1] <= negx[k];
        negy[k+1] <= negy[k];
      end
    end
  end

  // depth lookup
  logic        aok20;
  logic [15:0] dep_rd, dep;
  logic signed [43:0] dnum;

  always_ff @(posedge clk) begin
    if (adv) begin
      px       <= qx[NDIVX];
      py       <= qy[NDIVX];
      pix_addr <= pix_addr_nx;
      addr_ok  <= 32'(pix_addr_nx) < 32'(DEPTH_WORDS);
      aok20    <= addr_ok;
      dnum     <= $signed({12'b0, dep, 16'b0}) - 44'(slot[20].z) * 44'sd1000;
    end
  end

  assign dep = aok20 ? dep_rd : 16'd0;

  tvi_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH_WORDS)
  ) u_depth (
    .clk   (clk),
    .en    (adv),
    .we    (slot[19].valid && slot[19].wr),
    .addr  (slot[19].wr ? slot[19].waddr : ADDR_W'(pix_addr)),
    .wdata (slot[19].wdata),
    .rdata (dep_rd)
  );

  // truncated distance divider
  logic [56:0]       remt [NDIVT+1];
  logic [NDIVT-1:0]  qt [NDIVT+1];
  logic              negt [NDIVT+1], satt [NDIVT+1];
  logic [43:0]       magd;

  assign magd = dnum[43] ? 44'(-dnum) : 44'(dnum);

  always_ff @(posedge clk) begin
    if (adv) begin
      remt[0] <= (57'(magd) << 14) + 57'(lim >> 1);
      qt[0]   <= '0;
      negt[0] <= dnum[43];
      satt[0] <= dnum >= pos_lim;
      for (int k = 0; k < NDIVT; k++) begin
        if (remt[k] >= (57'(lim) << (NDIVT-1-k))) begin
          remt[k+1] <= remt[k] - (57'(lim) << (NDIVT-1-k));
          qt[k+1]   <= {qt[k][NDIVT-2:0], 1'b1};
        end else begin
          remt[k+1] <= remt[k];
          qt[k+1]   <= {qt[k][NDIVT-2:0], 1'b0};
        end
        negt[k+1] <= negt[k];
        satt[k+1] <= satt[k];
      end
    end
  end

  // weighted average divider
  logic signed [15:0] dq;
  logic signed [32:0] prod, num;
  logic [32:0]        mag3;
  logic [33:0]        rema [NDIVA+1];
  logic [NDIVA-1:0]   qa [NDIVA+1];
  logic               nega [NDIVA+1];
  logic [16:0]        wden [NDIVA+1];
  logic [16:0]        wden_nx;

  assign num     = prod + 33'(dq);
  assign mag3    = num[32] ? 33'(-num) : 33'(num);
  assign wden_nx = {1'b0, slot[38].ow} + 17'd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (satt[NDIVT]) begin
        dq <= 16'sd16384;
      end else if (negt[NDIVT]) begin
        dq <= -$signed({1'b0, qt[NDIVT]});
      end else begin
        dq <= $signed({1'b0, qt[NDIVT]});
      end
      prod    <= 33'(slot[S_DIVT+NDIVT].od) * $signed({17'b0, slot[S_DIVT+NDIVT].ow});
      rema[0] <= 34'(mag3) + 34'(wden_nx >> 1);
      qa[0]   <= '0;
      nega[0] <= num[32];
      wden[0] <= wden_nx;
      for (int k = 0; k < NDIVA; k++) begin
        if (rema[k] >= (34'(wden[k]) << (NDIVA-1-k))) begin
          rema[k+1] <= rema[k] - (34'(wden[k]) << (NDIVA-1-k));
          qa[k+1]   <= {qa[k][NDIVA-2:0], 1'b1};
        end else begin
          rema[k+1] <= rema[k];
          qa[k+1]   <= {qa[k][NDIVA-2:0], 1'b0};
        end
        nega[k+1] <= nega[k];
        wden[k+1] <= wden[k];
      end
    end
  end

  // output register
  logic [15:0]        nmag;
  logic signed [15:0] nd;

  always_comb begin
    nmag = (qa[NDIVA] > 17'd16384) ? 16'd16384 : qa[NDIVA][15:0];
    nd   = nega[NDIVA] ? -$signed(nmag) : $signed(nmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (adv) begin
      results.valid        <= slot[NST-1].valid;
      results.updated      <= slot[NST-1].live;
      results.new_distance <= slot[NST-1].live ? nd : slot[NST-1].od;
      if (!slot[NST-1].live) begin
        results.new_weight <= slot[NST-1].ow;
      end else if (slot[NST-1].ow == 16'hFFFF) begin
        results.new_weight <= 16'hFFFF;
      end else begin
        results.new_weight <= slot[NST-1].ow + 16'd1;
      end
    end
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tsdf_voxel_integrate_core: depth and frame loads,
// voxel fusion under several camera settings, random idling and backpressure.
// ----------------------------------------------------------------------------
module testbench
  import tvi_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0]         action;
    logic [19:0]        load_index;
    logic [15:0]        depth_mm;
    logic signed [31:0] frame_word;
    logic [9:0]         grid_x;
    logic [9:0]         grid_y;
    logic [9:0]         grid_z;
    logic signed [15:0] old_distance;
    logic [15:0]        old_weight;
  } voxel_item_t;

  typedef struct {
    logic               updated;
    logic signed [15:0] distance;
    logic [15:0]        weight;
  } fusion_t;

  logic clk;
  logic rst;

  tvi_in_if  items();
  tvi_out_if results();
  tvi_cfg_if cfg();

  tsdf_voxel_integrate_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg)
  );

  // camera and grid registers as the block should hold them
  logic [30:0]        focal_x, focal_y, voxel_sz, trunc_mg;
  logic signed [31:0] centre_x, centre_y;
  logic [10:0]        img_w, img_h;
  logic signed [31:0] frame_words [FRAME_WORDS];
  logic [15:0]        depth_mem [int];

  fusion_t fusion_q[$];
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_left;
  int      mismatches;
  int      items_sent;
  int      fused_seen;
  int      results_seen;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic wide_t sat32(wide_t v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  // round half away from zero, den > 0
  function automatic wide_t round_div(wide_t n, wide_t den);
    wide_t mag;
    wide_t q;
    mag = (n < 0) ? -n : n;
    q = (mag + den / 2) / den;
    return (n < 0) ? -q : q;
  endfunction

  function automatic bit project_pixel(wide_t n, wide_t den, wide_t lim, output wide_t q);
    wide_t mag;
    mag = (n < 0) ? -n : n;
    q = (mag + den / 2) / den;
    return !(n < 0 && q != 0) && q < lim;
  endfunction

  function automatic void fuse_voxel(input voxel_item_t it, output fusion_t r,
                                     output bit need_px, output int px_addr,
                                     output wide_t z_cam);
    wide_t dv [3];
    wide_t cam [3];
    wide_t g [3];
    wide_t s, px, py, dnum, lim, dq, nd, od, ow;
    r.updated  = 1'b0;
    r.distance = it.old_distance;
    r.weight   = it.old_weight;
    need_px    = 1'b0;
    px_addr    = 0;
    z_cam      = 0;
    g[0] = wide_t'(it.grid_x);
    g[1] = wide_t'(it.grid_y);
    g[2] = wide_t'(it.grid_z);
    for (int k = 0; k < 3; k++) begin
      dv[k] = sat32(wide_t'(frame_words[12+k]) + g[k] * wide_t'(voxel_sz)
                    - wide_t'(frame_words[9+k]));
    end
    for (int j = 0; j < 3; j++) begin
      s = 0;
      for (int k = 0; k < 3; k++) s += (wide_t'(frame_words[k*3+j]) * dv[k]) >>> 16;
      cam[j] = sat32(s);
    end
    z_cam = cam[2];
    if (cam[2] <= 0) return;
    if (!project_pixel(wide_t'(focal_x) * cam[0] + wide_t'(centre_x) * cam[2],
                       cam[2] <<< 16, wide_t'(img_w), px)) return;
    if (!project_pixel(wide_t'(focal_y) * cam[1] + wide_t'(centre_y) * cam[2],
                       cam[2] <<< 16, wide_t'(img_h), py)) return;
    px_addr = int'(py * wide_t'(img_w) + px);
    if (!depth_mem.exists(px_addr)) begin
      need_px = 1'b1;
      return;
    end
    // distances in units of 1/(1000*65536) metre
    dnum = wide_t'(depth_mem[px_addr]) * 65536 - cam[2] * 1000;
    lim  = wide_t'(trunc_mg) * 1000;
    if (dnum <= -lim) return;
    dq = (dnum >= lim) ? 128'sd16384 : round_div(dnum * 16384, lim);
    od = wide_t'(it.old_distance);
    ow = wide_t'(it.old_weight);
    nd = round_div(od * ow + dq, ow + 1);
    if (nd > 16384) nd = 16384;
    if (nd < -16384) nd = -16384;
    r.updated  = 1'b1;
    r.distance = nd[15:0];
    r.weight   = (it.old_weight == 16'hFFFF) ? 16'hFFFF : it.old_weight + 16'd1;
  endfunction

  // update the store model at acceptance and queue what the block must answer
  function automatic void accept_item(voxel_item_t it);
    fusion_t r;
    bit      need;
    int      addr;
    wide_t   z;
    r = '{1'b0, 16'sd0, 16'd0};
    case (it.action)
      ACT_DEPTH: depth_mem[int'(it.load_index)] = it.depth_mm;
      ACT_FRAME: if (it.load_index < FRAME_WORDS) frame_words[it.load_index] = it.frame_word;
      ACT_VOXEL: fuse_voxel(it, r, need, addr, z);
      default: ;
    endcase
    fusion_q.push_back(r);
    items_sent++;
  endfunction

  task automatic send_raw(voxel_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      items.valid = 1'b0;
      @(negedge clk);
    end
    items.action       = it.action;
    items.load_index   = it.load_index;
    items.depth_mm     = it.depth_mm;
    items.frame_word   = it.frame_word;
    items.grid_x       = it.grid_x;
    items.grid_y       = it.grid_y;
    items.grid_z       = it.grid_z;
    items.old_distance = it.old_distance;
    items.old_weight   = it.old_weight;
    items.valid        = 1'b1;
    do @(posedge clk); while (!items.ready);
    accept_item(it);
  endtask

  function automatic voxel_item_t random_fields();
    voxel_item_t it;
    it.action       = 2'($urandom_range(3));
    it.load_index   = 20'($urandom);
    it.depth_mm     = 16'($urandom);
    it.frame_word   = 32'($urandom);
    it.grid_x       = 10'($urandom);
    it.grid_y       = 10'($urandom);
    it.grid_z       = 10'($urandom);
    it.old_distance = 16'($urandom);
    it.old_weight   = 16'($urandom);
    return it;
  endfunction

  task automatic load_depth(int addr, logic [15:0] mm);
    voxel_item_t it;
    it = random_fields();
    it.action     = ACT_DEPTH;
    it.load_index = 20'(addr);
    it.depth_mm   = mm;
    send_raw(it);
  endtask

  task automatic load_frame(int idx, logic signed [31:0] word);
    voxel_item_t it;
    it = random_fields();
    it.action     = ACT_FRAME;
    it.load_index = 20'(idx);
    it.frame_word = word;
    send_raw(it);
  endtask

  // a voxel whose pixel was never loaded first gets that pixel, mostly near the surface
  task automatic send_voxel(voxel_item_t it);
    fusion_t r;
    bit      need;
    int      addr;
    wide_t   z;
    int      mm;
    int      pick;
    it.action = ACT_VOXEL;
    fuse_voxel(it, r, need, addr, z);
    if (need) begin
      pick = $urandom_range(99);
      mm = int'(z * 1000 / 65536) + $urandom_range(300) - 150;
      if (pick < 12) mm = 0;
      else if (pick < 25) mm = $urandom_range(65535);
      if (mm < 0) mm = 0;
      if (mm > 65535) mm = 65535;
      load_depth(addr, 16'(mm));
    end
    send_raw(it);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg.addr  = idx;
    cfg.data  = val;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_FOCAL_X:      focal_x  = val[30:0];
      REG_FOCAL_Y:      focal_y  = val[30:0];
      REG_CENTRE_X:     centre_x = val;
      REG_CENTRE_Y:     centre_y = val;
      REG_VOXEL_SIZE:   voxel_sz = val[30:0];
      REG_TRUNC_MARGIN: trunc_mg = val[30:0];
      REG_IMAGE_WIDTH:  img_w    = val[10:0];
      REG_IMAGE_HEIGHT: img_h    = val[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    items.valid = 1'b0;
    while (fusion_q.size() != 0) @(posedge clk);
  endtask

  // identity rotation looking down +z, grid box centred in front of the camera
  task automatic set_camera(int vs, int w, int h, int tm);
    wait_drained();
    write_reg(REG_VOXEL_SIZE, 32'(vs));
    write_reg(REG_TRUNC_MARGIN, 32'(tm));
    write_reg(REG_IMAGE_WIDTH, 32'(w));
    write_reg(REG_IMAGE_HEIGHT, 32'(h));
    write_reg(REG_FOCAL_X, 32'(w) << 16);
    write_reg(REG_FOCAL_Y, 32'(h) << 16);
    write_reg(REG_CENTRE_X, 32'(w) << 15);
    write_reg(REG_CENTRE_Y, 32'(h) << 15);
    for (int k = 0; k < 9; k++) load_frame(k, (k % 4 == 0) ? 32'sd65536 : 32'sd0);
    for (int k = 9; k < 12; k++) load_frame(k, $urandom_range(255) - 128);
    load_frame(12, -32 * vs);
    load_frame(13, -32 * vs);
    load_frame(14, 32 * vs);
  endtask

  function automatic voxel_item_t random_voxel();
    voxel_item_t it;
    int          pick;
    it = random_fields();
    it.action = ACT_VOXEL;
    if ($urandom_range(99) < 85) begin
      it.grid_x = 10'($urandom_range(63));
      it.grid_y = 10'($urandom_range(63));
      it.grid_z = 10'($urandom_range(63));
    end
    if ($urandom_range(99) < 80) it.old_distance = 16'($urandom_range(32768) - 16384);
    pick = $urandom_range(99);
    if (pick < 70) it.old_weight = 16'($urandom_range(100));
    else if (pick < 80) it.old_weight = 16'(16'hFFFF - $urandom_range(1));
    return it;
  endfunction

  task automatic run_random(int n);
    voxel_item_t it;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      it = random_fields();
      if (pick < 8) begin
        it.action = ACT_DEPTH;
        send_raw(it);
      end else if (pick < 12) begin
        // frame words out of range are dropped by the block
        it.action = ACT_FRAME;
        it.load_index = 20'($urandom_range(20'hFFFFF, FRAME_WORDS));
        send_raw(it);
      end else if (pick < 14) begin
        it.action = 2'd3;
        send_raw(it);
      end else begin
        send_voxel(random_voxel());
      end
    end
  endtask

  task automatic test_reset_defaults();
    voxel_item_t it;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 9; k++) load_frame(k, (k % 4 == 0) ? 32'sd65536 : 32'sd0);
    for (int k = 9; k < 14; k++) load_frame(k, 32'sd0);
    load_frame(14, 32'sd32768);
    for (int i = 0; i < 4; i++) send_voxel(random_voxel());
  endtask

  task automatic test_directed();
    voxel_item_t it;
    send_idle_pct = 11;
    recv_idle_pct = 88;
    set_camera(2621, 8, 6, 10486);
    load_depth(20'hFFFFF, 16'hFFFF);
    load_depth(0, 16'h0000);
    load_frame(20'hFFFFF, 32'sh80000000);
    load_frame(FRAME_WORDS, 32'sh7FFFFFFF);
    it = random_fields();
    it.action = 2'd3;
    it.load_index = 20'hFFFFF;
    send_raw(it);
    it = random_voxel();
    it.grid_x = 10'h3FF; it.grid_y = 10'h3FF; it.grid_z = 10'h3FF;
    send_voxel(it);
    it = random_voxel();
    it.grid_x = 0; it.grid_y = 0; it.grid_z = 0;
    it.old_distance = 16'sh8000; it.old_weight = 16'hFFFF;
    send_voxel(it);
    it.old_distance = 16'sh7FFF; it.old_weight = 16'hFFFE;
    send_voxel(it);
    it.grid_x = 32; it.grid_y = 32; it.grid_z = 10;
    it.old_distance = 16'sd16384; it.old_weight = 16'd0;
    send_voxel(it);
    it.old_distance = -16'sd16384;
    send_voxel(it);
    // origin far behind the camera, then saturating far in front
    load_frame(14, 32'sh80000000);
    send_voxel(it);
    load_frame(14, 32'sh7FFFFFFF);
    send_voxel(it);
    load_frame(14, 32 * 2621);
    // zero truncation margin: only surfaces in front are fused, at distance one
    wait_drained();
    write_reg(REG_TRUNC_MARGIN, 32'd0);
    run_random(12);
  endtask

  task automatic test_register_extremes();
    send_idle_pct = 88;
    recv_idle_pct = 11;
    set_camera(1, 1, 1, 1);
    run_random(10);
    set_camera(2621, 1024, 1024, 31'h7FFFFFFF);
    run_random(10);
    wait_drained();
    write_reg(REG_FOCAL_X, 32'h7FFFFFFF);
    write_reg(REG_FOCAL_Y, 32'h7FFFFFFF);
    write_reg(REG_CENTRE_X, 32'h80000000);
    write_reg(REG_CENTRE_Y, 32'h7FFFFFFF);
    write_reg(REG_VOXEL_SIZE, 32'h7FFFFFFF);
    run_random(10);
    // scrambled rotation and translation words
    set_camera(2621, 64, 48, 10486);
    for (int k = 0; k < 12; k++) load_frame(k, 32'($urandom));
    run_random(12);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 11;
    recv_idle_pct = 88;
    set_camera(2621, 640, 480, 10486);
    run_random(215);
    send_idle_pct = 88;
    recv_idle_pct = 11;
    set_camera(1311, 320, 240, 6554);
    run_random(215);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_camera(3277, 480, 640, 20000);
    run_random(215);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drained();
    hold_left = 300;
    run_random(120);
    // sender pauses until every transaction is back
    wait_drained();
    run_random(20);
  endtask

  // results sink: random stalls, or a long hold when asked
  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        results.ready = 1'b0;
      end else begin
        results.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    fusion_t e;
    if (!rst && results.valid && results.ready) begin
      results_seen++;
      if (fusion_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected transaction: updated %0b distance %0d weight %0d",
                   results.updated, results.new_distance, results.new_weight);
      end else begin
        e = fusion_q.pop_front();
        if (e.updated) fused_seen++;
        if (results.updated !== e.updated || results.new_distance !== e.distance ||
            results.new_weight !== e.weight) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected %0b/%0d/%0d got %0b/%0d/%0d", e.updated,
                     e.distance, e.weight, results.updated, results.new_distance,
                     results.new_weight);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((items.valid && items.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles = 0;
    end else if (fusion_q.size() != 0 || items.valid || cfg.valid) begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    items.valid = 1'b0;
    items.action = ACT_DEPTH;
    items.load_index = '0;
    items.depth_mm = '0;
    items.frame_word = '0;
    items.grid_x = '0;
    items.grid_y = '0;
    items.grid_z = '0;
    items.old_distance = '0;
    items.old_weight = '0;
    cfg.valid = 1'b0;
    cfg.addr = '0;
    cfg.data = '0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatches = 0;
    items_sent = 0;
    fused_seen = 0;
    results_seen = 0;
    quiet_cycles = 0;
    focal_x = '0;
    focal_y = '0;
    centre_x = '0;
    centre_y = '0;
    voxel_sz = VOXEL_SIZE_RST;
    trunc_mg = TRUNC_MARGIN_RST;
    img_w = IMAGE_WIDTH_RST;
    img_h = IMAGE_HEIGHT_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    repeat (80) @(posedge clk);

    $display("%0d items and %0d result transactions checked, %0d voxels fused",
             items_sent, results_seen, fused_seen);
    $display("covered loads, ignored words, register extremes, idling and a long stall");
    if (mismatches == 0 && fusion_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tvi_pkg.sv
rtl/tvi_if.sv
rtl/tvi_ram.sv
rtl/tsdf_voxel_integrate_core.sv
tb/sv/testbench.sv
